@@ rtl/nmsc_pkg.sv @@
// nmsc_pkg: shared types, constants and helpers for the n:m sparsity checker
// used by nmsc_ctrl, nmsc_dp and nm_sparsity_pattern_checker
package nmsc_pkg;

  localparam int unsigned MaxColumnsDef   = 1024;
  localparam int unsigned MaxBlockRowsDef = 32;

  localparam int unsigned CntW   = 6;
  localparam int unsigned NzW    = 6;
  localparam int unsigned ColCfgW = 11;
  localparam int unsigned ThrW   = 31;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned DivSteps = CntW;
  localparam int unsigned DivW   = 32 + CntW;
  localparam int unsigned StepW  = 3;

  localparam logic [NzW-1:0]     NzRst  = 6'd2;
  localparam logic [NzW-1:0]     RowsRst = 6'd4;
  localparam logic [ColCfgW-1:0] ColsRst = 11'd1;
  localparam logic [ThrW-1:0]    ThrRst  = 31'h358637BD;
  localparam logic [30:0]        ExpAllOnes = 31'h7F800000;

  typedef enum logic [IdxW-1:0] {
    REG_ALLOWED_NZ = 2'd0,
    REG_BLOCK_ROWS = 2'd1,
    REG_COL_COUNT  = 2'd2,
    REG_ZERO_THR   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             accept;
    logic             update;
    logic             div_init;
    logic             div_step;
    logic [StepW-1:0] div_bit;
    logic             load;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic bad;
  } dp_sts_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ rtl/nmsc_ram.sv @@
// nmsc_ram: generic single write port ram with registered read
// no dependencies
module nmsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/nmsc_ctrl.sv @@
// nmsc_ctrl: sequencer for accept, counter update, average division and result
// depends on nmsc_pkg
module nmsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nmsc_pkg::dp_cmd_t cmd_o,
  input  nmsc_pkg::dp_sts_t sts_i
);
  import nmsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             load;

  assign load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update   = (state_q == ST_UPD);
    cmd_o.div_init = (state_q == ST_PREP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.div_bit  = step_q;
    cmd_o.load     = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (!sts_i.last) state_q <= ST_IDLE;
          else if (sts_i.bad) state_q <= ST_OUT;
          else state_q <= ST_PREP;
        end
        ST_PREP: begin
          step_q  <= StepW'(DivSteps - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // quotient bits from msb down
          if (step_q == '0) state_q <= ST_OUT;
          else step_q <= step_q - 1'b1;
        end
        ST_OUT: begin
          if (load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

@@ rtl/nmsc_dp.sv @@
// nmsc_dp: config registers, column counter memory, tallies, divider, result regs
// depends on nmsc_pkg and nmsc_ram
module nmsc_dp #(
  parameter int unsigned MAX_COLUMNS    = nmsc_pkg::MaxColumnsDef,
  parameter int unsigned MAX_BLOCK_ROWS = nmsc_pkg::MaxBlockRowsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [nmsc_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [nmsc_pkg::CfgW-1:0] cfg_data_i,
  input  logic [31:0]               value_i,
  input  logic                      last_i,
  input  nmsc_pkg::dp_cmd_t         cmd_i,
  output nmsc_pkg::dp_sts_t         sts_o,
  output logic                      pattern_ok_o,
  output logic                      config_error_o,
  output logic [31:0]               over_blocks_o,
  output logic [31:0]               block_count_o,
  output logic [nmsc_pkg::CntW-1:0] avg_nonzeros_o
);
  import nmsc_pkg::*;

  localparam int unsigned ColW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RowW = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;

  logic [NzW-1:0]     cfg_n_q, cfg_m_q;
  logic [ColCfgW-1:0] cfg_cols_q;
  logic [ThrW-1:0]    cfg_thr_q;

  logic [31:0]      value_q;
  logic             last_q, bad_q;
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [31:0]      blocks_q, badblk_q, total_q;
  logic [DivW-1:0]  rem_q;
  logic [CntW-1:0]  quo_q;

  logic             cfg_bad;
  logic [31:0]      cols;
  logic [30:0]      mag;
  logic             nz;
  logic [CntW-1:0]  ram_rdata, cnt_base, cnt;
  logic [CntW:0]    cnt_sum;
  logic             blk_end, col_end, upd;
  logic [DivW-1:0]  div_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q    <= NzRst;
      cfg_m_q    <= RowsRst;
      cfg_cols_q <= ColsRst;
      cfg_thr_q  <= ThrRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ALLOWED_NZ: cfg_n_q    <= cfg_data_i[NzW-1:0];
        REG_BLOCK_ROWS: cfg_m_q    <= cfg_data_i[NzW-1:0];
        REG_COL_COUNT:  cfg_cols_q <= cfg_data_i[ColCfgW-1:0];
        REG_ZERO_THR:   cfg_thr_q  <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_bad = (cfg_m_q == '0) || (cfg_n_q == '0) || (cfg_n_q > cfg_m_q) ||
                   (32'(cfg_m_q) > 32'(MAX_BLOCK_ROWS));
  assign cols = (cfg_cols_q == '0) ? 32'd1 :
                (32'(cfg_cols_q) > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : 32'(cfg_cols_q);

  // nan patterns never count as nonzero
  assign mag      = value_q[30:0];
  assign nz       = !(mag > ExpAllOnes) && (mag > cfg_thr_q);
  assign cnt_base = (row_q == '0) ? '0 : ram_rdata;
  assign cnt_sum  = {1'b0, cnt_base} + (CntW+1)'(nz);
  assign cnt      = cnt_sum[CntW] ? '1 : cnt_sum[CntW-1:0];
  assign blk_end  = (32'(row_q) + 32'd1) >= 32'(cfg_m_q);
  assign col_end  = (32'(col_q) + 32'd1) >= cols;
  assign upd      = cmd_i.update && !bad_q;

  nmsc_ram #(.Width(CntW), .Depth(MAX_COLUMNS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (col_q),
    .wdata_i (cnt),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= value_i;
    end
  end

  assign div_sub = {{CntW{1'b0}}, blocks_q} << cmd_i.div_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      bad_q    <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      blocks_q <= '0;
      badblk_q <= '0;
      total_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= last_i;
        bad_q  <= cfg_bad;
      end
      if (upd) begin
        if (blk_end) begin
          blocks_q <= sat_add32(blocks_q, 32'd1);
          total_q  <= sat_add32(total_q, 32'(cnt));
          if (cnt > cfg_n_q) badblk_q <= sat_add32(badblk_q, 32'd1);
        end
        if (col_end) begin
          col_q <= '0;
          row_q <= blk_end ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (cmd_i.load) begin
        col_q    <= '0;
        row_q    <= '0;
        blocks_q <= '0;
        badblk_q <= '0;
        total_q  <= '0;
      end
    end
  end

  // restoring division, quotient never exceeds the 6-bit count range
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= {{CntW{1'b0}}, total_q};
      quo_q <= '0;
    end else if (cmd_i.div_step && (rem_q >= div_sub)) begin
      rem_q                <= rem_q - div_sub;
      quo_q[cmd_i.div_bit] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pattern_ok_o     <= !bad_q && (badblk_q == '0);
      config_error_o   <= bad_q;
      over_blocks_o    <= bad_q ? '0 : badblk_q;
      block_count_o    <= bad_q ? '0 : blocks_q;
      avg_nonzeros_o   <= (bad_q || blocks_q == '0) ? '0 : quo_q;
    end
  end

  assign sts_o.last = last_q;
  assign sts_o.bad  = bad_q;
endmodule

@@ rtl/nm_sparsity_pattern_checker.sv @@
// channel | handshake            | payload
// in      | in_valid_i/in_stall_o | value_i, last_i
// out     | out_valid_o/out_stall_i | pattern_ok_o, config_error_o, over_blocks_o,
//         |                      | block_count_o, avg_nonzeros_o
// an element takes a column counter read, then its write-back
// a last element with a good setting adds setup and the divider steps (ST_PREP, ST_DIV), with a bad
// setting none; then ST_OUT loads the result register
// a full result register stalls the block until taken
// async active-low reset clears stream counters; counter memory is not cleared
// top level; depends on nmsc_pkg, nmsc_ctrl, nmsc_dp, nmsc_ram
module nm_sparsity_pattern_checker #(
  parameter int unsigned MAX_COLUMNS    = nmsc_pkg::MaxColumnsDef,
  parameter int unsigned MAX_BLOCK_ROWS = nmsc_pkg::MaxBlockRowsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [nmsc_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [nmsc_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [31:0]               value_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      pattern_ok_o,
  output logic                      config_error_o,
  output logic [31:0]               over_blocks_o,
  output logic [31:0]               block_count_o,
  output logic [nmsc_pkg::CntW-1:0] avg_nonzeros_o
);
  import nmsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  nmsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nmsc_dp #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_BLOCK_ROWS(MAX_BLOCK_ROWS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .value_i          (value_i),
    .last_i           (last_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pattern_ok_o     (pattern_ok_o),
    .config_error_o   (config_error_o),
    .over_blocks_o    (over_blocks_o),
    .block_count_o    (block_count_o),
    .avg_nonzeros_o   (avg_nonzeros_o)
  );
endmodule

@@ rtl/nmsc_checker.sv @@
// nmsc_checker: port-level checks on the n:m sparsity checker, bound to the top
// depends on nmsc_pkg and nm_sparsity_pattern_checker
module nmsc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      pattern_ok_o,
  input logic                      config_error_o,
  input logic [31:0]               over_blocks_o,
  input logic [31:0]               block_count_o,
  input logic [nmsc_pkg::CntW-1:0] avg_nonzeros_o
);
  import nmsc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_count_o) &&
    $stable(over_blocks_o) && $stable(avg_nonzeros_o))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && config_error_o |-> !pattern_ok_o && block_count_o == '0 &&
    over_blocks_o == '0 && avg_nonzeros_o == '0)
    else $error("config error result carries counts");

  a_valid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_ok_o |-> over_blocks_o == '0 && !config_error_o)
    else $error("passing result reports bad blocks");

  // an accepted element always raises the input stall, so no two elements are taken back to back
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");
endmodule

bind nm_sparsity_pattern_checker nmsc_checker u_nmsc_checker (.*);

@@ dv/nm_sparsity_pattern_checker_test.sv @@
// self-checking testbench for nm_sparsity_pattern_checker: streams tensors and checks each
// end-of-tensor summary against an in-bench predictor; depends on nmsc_pkg and the rtl
module nm_sparsity_pattern_checker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nmsc_pkg::*;

  typedef struct packed {
    logic        pattern_ok;
    logic        config_error;
    logic [31:0] over_blocks;
    logic [31:0] block_count;
    logic [5:0]  avg_nonzeros;
  } summary_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IdxW-1:0]   cfg_idx_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [31:0]       value_i = '0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              pattern_ok_o, config_error_o;
  logic [31:0]       over_blocks_o, block_count_o;
  logic [CntW-1:0]   avg_nonzeros_o;

  nm_sparsity_pattern_checker dut (.*);

  always #4 clk_i = ~clk_i;

  // mirrored configuration and stream state
  logic [5:0]  allowed_nz = 6'd2;
  logic [5:0]  rows_per_block = 6'd4;
  logic [10:0] ncols = 11'd1;
  logic [30:0] thr = 31'h358637BD;
  logic [5:0]  col_nz [1024];
  int unsigned col_pos, row_pos;
  logic [31:0] blocks, bad_blocks, nz_total;

  summary_t    pending_summaries [$];
  int unsigned errors = 0, beats_sent = 0, summaries_seen = 0;
  bit          idle_on = 1'b1;

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_tensor();
    col_pos = 0; row_pos = 0; blocks = 0; bad_blocks = 0; nz_total = 0;
  endfunction

  // apply one element to the predicted state; queue a summary on last
  function automatic void predict_element(logic [31:0] v, logic l);
    bit          cfg_bad;
    logic [30:0] mag;
    int unsigned cols, cnt, avg;
    summary_t    s;
    cfg_bad = rows_per_block == 0 || allowed_nz == 0 || allowed_nz > rows_per_block ||
              rows_per_block > 32;
    if (!cfg_bad) begin
      mag = v[30:0];
      cols = (ncols == 0) ? 1 : (ncols > 1024) ? 1024 : ncols;
      cnt = (row_pos == 0) ? 0 : col_nz[col_pos];
      if (mag <= ExpAllOnes && mag > thr) cnt++;
      if (cnt > 63) cnt = 63;
      col_nz[col_pos] = 6'(cnt);
      if (row_pos + 1 >= rows_per_block) begin
        blocks = sat_inc(blocks, 32'd1);
        nz_total = sat_inc(nz_total, cnt);
        if (cnt > allowed_nz) bad_blocks = sat_inc(bad_blocks, 32'd1);
      end
      if (col_pos + 1 >= cols) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= rows_per_block) ? 0 : ((row_pos + 1) & 31);
      end else begin
        col_pos++;
      end
    end
    if (!l) return;
    if (cfg_bad) begin
      s = '{1'b0, 1'b1, 32'd0, 32'd0, 6'd0};
    end else begin
      avg = (blocks != 0) ? nz_total / blocks : 0;
      if (avg > 63) avg = 63;
      s = '{bad_blocks == 0, 1'b0, bad_blocks, blocks, avg[5:0]};
    end
    pending_summaries.push_back(s);
    clear_tensor();
  endfunction

  task automatic send_element(logic [31:0] v, logic l);
    while (idle_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_element(v, l);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // block is idle here: all summaries taken and the pipeline has settled
  task automatic write_reg(reg_idx_e idx, logic [30:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ALLOWED_NZ: allowed_nz = data[5:0];
      REG_BLOCK_ROWS: rows_per_block = data[5:0];
      REG_COL_COUNT:  ncols = data[10:0];
      REG_ZERO_THR:   thr = data;
      default: ;
    endcase
  endtask

  task automatic configure(int n, int m, int c, logic [30:0] t);
    write_reg(REG_ALLOWED_NZ, 31'(n));
    write_reg(REG_BLOCK_ROWS, 31'(m));
    write_reg(REG_COL_COUNT, 31'(c));
    write_reg(REG_ZERO_THR, t);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 31'd0};
      1: return {1'($urandom_range(1)), thr};
      2: return {1'($urandom_range(1)), thr + 31'd1};
      3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_tensor(int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_element(pick_value(), i == len);
  endtask

  // reset settings: signed zeros, threshold edge, infinities and nans
  task automatic test_reset_defaults();
    send_element(32'h0000_0000, 0);
    send_element(32'h8000_0000, 0);
    send_element(32'h3586_37BD, 0);
    send_element(32'hB586_37BE, 0);
    send_element(32'h7F80_0000, 0);
    send_element(32'hFF80_0000, 0);
    send_element(32'h7FC0_0001, 0);
    send_element(32'hFFFF_FFFF, 1);
  endtask

  task automatic test_bad_config();
    configure(0, 4, 2, 0);
    send_tensor(5);
    configure(5, 4, 2, 0);
    send_tensor(5);
    configure(1, 0, 2, 0);
    send_tensor(5);
    configure(2, 33, 2, 0);
    send_tensor(5);
    configure(63, 63, 1, 0);
    send_tensor(3);
  endtask

  task automatic test_extremes();
    configure(32, 32, 1, 0);
    for (int i = 0; i < 32; i++) send_element(32'h0000_0001, i == 31);
    configure(1, 1, 0, 31'h7F7FFFFF);
    send_element(32'h7F80_0000, 0);
    send_element(32'h7F7F_FFFF, 1);
    // column count above the limit wraps rows at the limit
    configure(1, 2, 2047, 31'd0);
    send_tensor(1030);
    configure(2, 3, 4, 31'h358637BD);
    send_tensor(7);  // no complete block: average zero
    send_tensor(14); // ends inside a row
  endtask

  task automatic test_random(int unsigned target);
    int unsigned start, m;
    start = beats_sent;
    while (beats_sent - start < target) begin
      idle_on = !(beats_sent - start > target / 3 && beats_sent - start < target / 2);
      m = $urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(1, 8);
      configure($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(1, m > 0 ? m : 1),
                m, $urandom_range(9) == 0 ? $urandom_range(2047) : $urandom_range(1, 8),
                31'($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 2139095039)));
      repeat ($urandom_range(1, 4)) send_tensor($urandom_range(1, 60));
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk_i) out_stall_i <= idle_on && $urandom_range(99) < 12;

  always @(posedge clk_i) begin
    summary_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      summaries_seen++;
      if (pending_summaries.size() == 0) begin
        $display("%0t: unexpected summary beat", $time);
        errors++;
      end else begin
        exp_s = pending_summaries.pop_front();
        if (pattern_ok_o !== exp_s.pattern_ok) begin
          $display("%0t: pattern_ok exp %0d got %0d", $time, exp_s.pattern_ok, pattern_ok_o);
          errors++;
        end
        if (config_error_o !== exp_s.config_error) begin
          $display("%0t: config_error exp %0d got %0d", $time, exp_s.config_error,
                   config_error_o);
          errors++;
        end
        if (over_blocks_o !== exp_s.over_blocks) begin
          $display("%0t: over_blocks exp %0d got %0d", $time, exp_s.over_blocks,
                   over_blocks_o);
          errors++;
        end
        if (block_count_o !== exp_s.block_count) begin
          $display("%0t: block_count exp %0d got %0d", $time, exp_s.block_count,
                   block_count_o);
          errors++;
        end
        if (avg_nonzeros_o !== exp_s.avg_nonzeros) begin
          $display("%0t: avg_nonzeros exp %0d got %0d", $time, exp_s.avg_nonzeros,
                   avg_nonzeros_o);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_tensor();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_bad_config();
    test_extremes();
    test_random(400);
    drain();
    $display("sent %0d elements, checked %0d tensor summaries", beats_sent, summaries_seen);
    $display("covered reset values, bad settings, extreme settings and random settings");
    if (errors == 0 && pending_summaries.size() == 0) begin
      $display("nm_sparsity_pattern_checker: match");
    end else begin
      $display("nm_sparsity_pattern_checker: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("nm_sparsity_pattern_checker: mismatch");
    $finish;
  end
endmodule
